/* hw/rtl/qrs_pkg.sv */
// Shared constants, register indexes and types of the QRS peak detector.
`timescale 1ns / 1ps

package qrs_pkg;

	// Derivative lag and sample counter width
	localparam int DIFF_LAG   = 4;
	localparam int COUNT_BITS = 32;

	// Signed position (count - lag) and signed confirmation deadline
	localparam int POS_W = COUNT_BITS + 1;
	localparam int AT_W  = COUNT_BITS + 2;

	localparam int SAMPLE_W   = 16;
	localparam int HEIGHT_W   = 16;
	localparam int CAND_W     = HEIGHT_W + 1;
	localparam int Q_W        = 32;
	localparam int FRAC_W     = 16;
	localparam int WAIT_W     = 12;
	localparam int OUT_POS_W  = 32;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	// Configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_START   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_FLOOR   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_DECAY_FACTOR      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PEAK_FRACTION     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_WAIT      = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_REFRACTORY_LENGTH = 3'd5;

	// Reset values of the registers
	localparam logic [HEIGHT_W-1:0] THRESHOLD_START_RST   = 16'd200;
	localparam logic [HEIGHT_W-1:0] THRESHOLD_FLOOR_RST   = 16'd60;
	localparam logic [FRAC_W-1:0]   DECAY_FACTOR_RST      = 16'd65529;
	localparam logic [FRAC_W-1:0]   PEAK_FRACTION_RST     = 16'd39322;
	localparam logic [WAIT_W-1:0]   CONFIRM_WAIT_RST      = 12'd72;
	localparam logic [WAIT_W-1:0]   REFRACTORY_LENGTH_RST = 12'd90;

	typedef struct packed {
		logic [HEIGHT_W-1:0] threshold_floor;
		logic [FRAC_W-1:0]   decay_factor;
		logic [FRAC_W-1:0]   peak_fraction;
		logic [WAIT_W-1:0]   confirm_wait;
		logic [WAIT_W-1:0]   refractory_length;
	} cfg_t;

	typedef struct packed {
		logic                        beat_found;
		logic signed [OUT_POS_W-1:0] peak_position;
		logic [HEIGHT_W-1:0]         peak_height;
	} result_t;

endpackage

/* hw/rtl/qrs_ifs.sv */
// Handshake channels of the QRS peak detector: samples, results and register writes.
`timescale 1ns / 1ps

interface qrs_in_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [qrs_pkg::SAMPLE_W-1:0]   sample;

	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface qrs_out_if;
	logic                                  valid;
	logic                                  ready;
	logic                                  beat_found;
	logic signed [qrs_pkg::OUT_POS_W-1:0]  peak_position;
	logic [qrs_pkg::HEIGHT_W-1:0]          peak_height;

	modport source (output valid, output beat_found, output peak_position,
		output peak_height, input ready);
	modport sink   (input valid, input beat_found, input peak_position,
		input peak_height, output ready);
endinterface

interface qrs_cfg_if;
	logic                                  valid;
	logic                                  ready;
	logic [qrs_pkg::CFG_IDX_W-1:0]         index;
	logic [qrs_pkg::CFG_DATA_W-1:0]        data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

/* hw/rtl/qrs_cfg.sv */
// Configuration register file of the QRS peak detector.
`timescale 1ns / 1ps

module qrs_cfg (
	input  logic             clk,
	input  logic             arst_n,
	qrs_cfg_if.sink          cfg_ch,
	output qrs_pkg::cfg_t    cfg
);

	qrs_pkg::cfg_t cfg_q;

	assign cfg_ch.ready = 1'b1;
	assign cfg      = cfg_q;

	// threshold_start is only seen at reset, which also restores it: take the beat, drop it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.threshold_floor   <= qrs_pkg::THRESHOLD_FLOOR_RST;
			cfg_q.decay_factor      <= qrs_pkg::DECAY_FACTOR_RST;
			cfg_q.peak_fraction     <= qrs_pkg::PEAK_FRACTION_RST;
			cfg_q.confirm_wait      <= qrs_pkg::CONFIRM_WAIT_RST;
			cfg_q.refractory_length <= qrs_pkg::REFRACTORY_LENGTH_RST;
		end else if (cfg_ch.valid) begin
			unique case (cfg_ch.index)
				qrs_pkg::REG_THRESHOLD_FLOOR:   cfg_q.threshold_floor   <= cfg_ch.data;
				qrs_pkg::REG_DECAY_FACTOR:      cfg_q.decay_factor      <= cfg_ch.data;
				qrs_pkg::REG_PEAK_FRACTION:     cfg_q.peak_fraction     <= cfg_ch.data;
				qrs_pkg::REG_CONFIRM_WAIT:
					cfg_q.confirm_wait <= cfg_ch.data[qrs_pkg::WAIT_W-1:0];
				qrs_pkg::REG_REFRACTORY_LENGTH:
					cfg_q.refractory_length <= cfg_ch.data[qrs_pkg::WAIT_W-1:0];
				default: ;
			endcase
		end
	end

endmodule

/* hw/rtl/qrs_engine.sv */
// Detector state and per-sample update: delay line, threshold and phase machine.
`timescale 1ns / 1ps

module qrs_engine (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic signed [qrs_pkg::SAMPLE_W-1:0] sample,
	input  qrs_pkg::cfg_t                       cfg,
	output qrs_pkg::result_t                    result
);

	localparam logic [1:0] PH_RESET   = 2'd0;
	localparam logic [1:0] PH_LOOKING = 2'd1;
	localparam logic [1:0] PH_PROV    = 2'd2;
	localparam logic [1:0] PH_HALF    = 2'd3;

	localparam int CB = qrs_pkg::COUNT_BITS;
	localparam int PW = qrs_pkg::POS_W;
	localparam int AW = qrs_pkg::AT_W;
	localparam int HW = qrs_pkg::HEIGHT_W;
	localparam int CW = qrs_pkg::CAND_W;
	localparam int QW = qrs_pkg::Q_W;
	localparam int FW = qrs_pkg::FRAC_W;

	// Previous DIFF_LAG samples, entry 0 the oldest
	logic signed [qrs_pkg::SAMPLE_W-1:0] taps_q [qrs_pkg::DIFF_LAG];

	logic [1:0]            phase_q, phase_d;
	logic [QW-1:0]         thr_q, thr_d;
	logic [CB-1:0]         count_q;
	logic signed [CW-1:0]  cand_h_q, cand_h_d;
	logic signed [PW-1:0]  cand_pos_q, cand_pos_d;
	logic signed [CW-1:0]  best_h_q, best_h_d;
	logic signed [PW-1:0]  best_pos_q, best_pos_d;
	logic signed [AW-1:0]  confirm_at_q, confirm_at_d;
	logic [CB-1:0]         blind_q, blind_d;

	logic signed [HW:0]    diff;
	logic [HW-1:0]         mag;
	logic signed [CW-1:0]  mag_s;
	logic signed [PW-1:0]  pos;
	logic [QW+FW-1:0]      decay_prod;
	logic [QW-1:0]         thr_decayed;
	logic [QW-1:0]         floor_q16;
	logic signed [CW-1:0]  prov_h;
	logic signed [PW-1:0]  prov_pos;
	logic signed [CW-1:0]  half_h;
	logic [HW-1:0]         best_h_u;
	logic signed [63:0]    best_pos_ext;

	assign diff  = (HW+1)'(sample) - (HW+1)'(taps_q[0]);
	assign mag   = diff[HW] ? HW'(-diff) : HW'(diff);
	assign mag_s = $signed({1'b0, mag});
	assign pos   = $signed({1'b0, count_q}) - PW'(qrs_pkg::DIFF_LAG);

	// Decay then floor, on every sample
	assign decay_prod  = (QW+FW)'(thr_q) * (QW+FW)'(cfg.decay_factor);
	assign thr_decayed = decay_prod[QW+FW-1:FW];
	assign floor_q16   = {cfg.threshold_floor, {FW{1'b0}}};

	// Candidate tracking while a provisional peak is open
	assign prov_h   = (mag_s > cand_h_q) ? mag_s : cand_h_q;
	assign prov_pos = (mag_s > cand_h_q) ? pos : cand_pos_q;
	assign half_h   = (prov_h + (prov_h[CW-1] ? CW'(1) : CW'(0))) >>> 1;

	assign best_h_u     = best_h_q[CW-1] ? '0 : best_h_q[HW-1:0];
	assign best_pos_ext = 64'(best_pos_q);

	always_comb begin
		phase_d      = phase_q;
		thr_d        = (thr_decayed < floor_q16) ? floor_q16 : thr_decayed;
		cand_h_d     = cand_h_q;
		cand_pos_d   = cand_pos_q;
		best_h_d     = best_h_q;
		best_pos_d   = best_pos_q;
		confirm_at_d = confirm_at_q;
		blind_d      = blind_q;
		result       = '0;
		unique case (phase_q)
			PH_RESET: begin
				cand_h_d = '1;
				phase_d  = PH_LOOKING;
			end
			PH_LOOKING: begin
				if (count_q > blind_q && {mag, {FW{1'b0}}} > thr_d) begin
					cand_h_d   = mag_s;
					cand_pos_d = pos;
					phase_d    = PH_PROV;
				end
			end
			PH_PROV: begin
				cand_h_d   = prov_h;
				cand_pos_d = prov_pos;
				if (mag_s < half_h) begin
					best_h_d     = prov_h;
					best_pos_d   = prov_pos;
					confirm_at_d = AW'(prov_pos) + AW'(cfg.confirm_wait);
					phase_d      = PH_HALF;
				end
			end
			PH_HALF: begin
				if (mag_s > best_h_q) begin
					// candidate position stays as it was
					best_h_d   = mag_s;
					best_pos_d = pos;
					cand_h_d   = mag_s;
					phase_d    = PH_PROV;
				end else if ($signed({2'b00, count_q}) >= confirm_at_q) begin
					result.beat_found    = 1'b1;
					result.peak_position = best_pos_ext[qrs_pkg::OUT_POS_W-1:0];
					result.peak_height   = best_h_u;
					thr_d   = QW'(best_h_u) * QW'(cfg.peak_fraction);
					blind_d = count_q + CB'(cfg.refractory_length);
					phase_d = PH_RESET;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < qrs_pkg::DIFF_LAG; i++) begin
				taps_q[i] <= '0;
			end
			phase_q      <= PH_RESET;
			thr_q        <= {qrs_pkg::THRESHOLD_START_RST, {FW{1'b0}}};
			count_q      <= '0;
			cand_h_q     <= '1;
			cand_pos_q   <= '1;
			best_h_q     <= '1;
			best_pos_q   <= '1;
			confirm_at_q <= '1;
			blind_q      <= '0;
		end else if (step) begin
			for (int i = 0; i < qrs_pkg::DIFF_LAG - 1; i++) begin
				taps_q[i] <= taps_q[i+1];
			end
			taps_q[qrs_pkg::DIFF_LAG-1] <= sample;
			phase_q      <= phase_d;
			thr_q        <= thr_d;
			count_q      <= count_q + CB'(1);
			cand_h_q     <= cand_h_d;
			cand_pos_q   <= cand_pos_d;
			best_h_q     <= best_h_d;
			best_pos_q   <= best_pos_d;
			confirm_at_q <= confirm_at_d;
			blind_q      <= blind_d;
		end
	end

endmodule

/* hw/rtl/qrs_peak_detector_core.sv */
// Top level of the QRS peak detector: input register, detector engine, result register.
`timescale 1ns / 1ps

// Channel   Direction  Beat contents
// in_ch     sink       sample (signed 16 bit ECG sample)
// out_ch    source     beat_found, peak_position (signed 32), peak_height (16)
// cfg_ch    sink       index (3 bit), data (16 bit); always ready
//
// One sample is accepted per cycle while out_ch takes results, and one result
// beat leaves per sample. The sample is held in an input register, then the
// engine updates its state and loads the result register on the same edge.
// The threshold feedback (multiply, floor, compare) is combinational up to thr_q.
// Reset clears the delay line, phase, counters and threshold to their start values.
// A stall on out_ch holds the result; the input register still takes one
// more sample, after which in_ch.ready drops until the result is taken.

module qrs_peak_detector_core (
	input  logic       clk,
	input  logic       arst_n,
	qrs_in_if.sink     in_ch,
	qrs_out_if.source  out_ch,
	qrs_cfg_if.sink    cfg_ch
);

	qrs_pkg::cfg_t    cfg;
	qrs_pkg::result_t result;
	qrs_pkg::result_t result_q;

	logic                                valid_s1;
	logic signed [qrs_pkg::SAMPLE_W-1:0] sample_s1;
	logic                                out_valid_q;
	logic                                step;

	// Advance the held sample whenever the result register is free or draining
	assign step        = valid_s1 && (!out_valid_q || out_ch.ready);
	assign in_ch.ready = !valid_s1 || step;

	qrs_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_ch (cfg_ch),
		.cfg    (cfg)
	);

	qrs_engine u_engine (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.sample (sample_s1),
		.cfg    (cfg),
		.result (result)
	);

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.valid && in_ch.ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_s1 <= in_ch.sample;
		end
	end

	// Result register: load on each step, drop the valid once the beat is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step) begin
			out_valid_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			result_q <= result;
		end
	end

	assign out_ch.valid         = out_valid_q;
	assign out_ch.beat_found    = result_q.beat_found;
	assign out_ch.peak_position = result_q.peak_position;
	assign out_ch.peak_height   = result_q.peak_height;

endmodule

/* verif/testbench.sv */
// Self-checking testbench of the QRS peak detector core, with its own beat predictor.
`timescale 1ns / 1ps

module testbench;
	import qrs_pkg::*;

	// Cycles with no beat on any channel before the run is abandoned
	localparam int WATCHDOG_LIMIT = 3000;
	// Receiver hold-off that backs the pipeline up into the sample channel
	localparam int LONG_HOLD      = 300;
	// Settle time after the last result; the core holds an input and a result register
	localparam int SETTLE_CYCLES  = 8;

	// Phases of the detector as the predictor tracks them
	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_SEEK,
		ST_PEAK,
		ST_SETTLE
	} det_phase_e;

	logic clk = 1'b0;
	logic arst_n;

	qrs_in_if  in_ch ();
	qrs_out_if out_ch ();
	qrs_cfg_if cfg_ch ();

	qrs_peak_detector_core dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch),
		.cfg_ch (cfg_ch)
	);

	always #5 clk = ~clk;

	// Samples waiting to be offered, and results the predictor has worked out
	logic signed [SAMPLE_W-1:0] sample_q [$];
	result_t                    predicted_results [$];

	// Register copy of the predictor; the start level only matters at reset
	cfg_t                det_cfg;
	logic [HEIGHT_W-1:0] start_level;

	// Detector state of the predictor
	det_phase_e                 det_phase;
	logic [Q_W-1:0]             thr_q16;
	logic [COUNT_BITS-1:0]      sample_cnt;
	logic [COUNT_BITS-1:0]      blind_until;
	logic signed [SAMPLE_W-1:0] sample_hist [0:DIFF_LAG];
	longint                     cand_h, cand_pos, best_h, best_pos, confirm_at;

	int fault_cnt = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int phase_items;
	int hold_req = 0;
	int hold_seen;
	int hold_left;
	int quiet_cycles;

	// Advance the predictor by one sample and return the result beat it causes
	function automatic result_t detect_qrs(input logic signed [SAMPLE_W-1:0] s);
		result_t             r;
		logic [63:0]         thr_wide;
		logic [HEIGHT_W-1:0] peak_h;
		longint              diff, mag, pos;
		r = '0;

		// Decay and floor come first on every sample, confirmation included
		thr_wide = 64'(thr_q16) * 64'(det_cfg.decay_factor);
		thr_q16  = thr_wide[47:16];
		if (thr_q16 < {det_cfg.threshold_floor, 16'd0})
			thr_q16 = {det_cfg.threshold_floor, 16'd0};

		for (int i = 0; i < DIFF_LAG; i++)
			sample_hist[i] = sample_hist[i+1];
		sample_hist[DIFF_LAG] = s;
		diff = longint'(sample_hist[DIFF_LAG]) - longint'(sample_hist[0]);
		mag  = (diff < 0) ? -diff : diff;
		pos  = longint'(sample_cnt) - DIFF_LAG;

		case (det_phase)
			ST_CLEAR: begin
				cand_h    = -1;
				det_phase = ST_SEEK;
			end
			ST_SEEK: begin
				if (sample_cnt > blind_until && (mag <<< 16) > longint'(thr_q16)) begin
					cand_h    = mag;
					cand_pos  = pos;
					det_phase = ST_PEAK;
				end
			end
			ST_PEAK: begin
				if (mag > cand_h) begin
					cand_h   = mag;
					cand_pos = pos;
				end
				// Division truncates toward zero, as the half-drop test wants
				if (mag < cand_h / 2) begin
					best_h     = cand_h;
					best_pos   = cand_pos;
					confirm_at = best_pos + longint'(det_cfg.confirm_wait);
					det_phase  = ST_SETTLE;
				end
			end
			default: begin
				// A higher slope reopens the peak but keeps the old candidate position
				if (mag > best_h) begin
					best_h    = mag;
					best_pos  = pos;
					cand_h    = mag;
					det_phase = ST_PEAK;
				end else if (longint'(sample_cnt) >= confirm_at) begin
					peak_h          = (best_h < 0) ? '0 : best_h[HEIGHT_W-1:0];
					r.beat_found    = 1'b1;
					r.peak_position = best_pos[OUT_POS_W-1:0];
					r.peak_height   = peak_h;
					thr_q16         = Q_W'(peak_h) * Q_W'(det_cfg.peak_fraction);
					blind_until     = sample_cnt + COUNT_BITS'(det_cfg.refractory_length);
					det_phase       = ST_CLEAR;
				end
			end
		endcase

		sample_cnt = sample_cnt + COUNT_BITS'(1);
		return r;
	endfunction

	// Driver: predict each accepted sample, then offer the next one unless idling
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid  <= 1'b0;
			in_ch.sample <= '0;
		end else begin
			if (in_ch.valid && in_ch.ready)
				predicted_results.push_back(detect_qrs(in_ch.sample));
			if (!in_ch.valid || in_ch.ready) begin
				if (sample_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_ch.valid  <= 1'b1;
					in_ch.sample <= sample_q.pop_front();
				end else begin
					in_ch.valid  <= 1'b0;
				end
			end
		end
	end

	// Monitor: compare each result beat with the oldest prediction; also drive ready
	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			hold_seen    <= 0;
			hold_left    <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (predicted_results.size() == 0) begin
					$error("result beat with no prediction waiting");
					fault_cnt++;
				end else begin
					want = predicted_results.pop_front();
					if (out_ch.beat_found !== want.beat_found) begin
						$error("beat_found: expected %0d, got %0d",
							want.beat_found, out_ch.beat_found);
						fault_cnt++;
					end
					if (out_ch.peak_position !== want.peak_position) begin
						$error("peak_position: expected %0d, got %0d",
							want.peak_position, out_ch.peak_position);
						fault_cnt++;
					end
					if (out_ch.peak_height !== want.peak_height) begin
						$error("peak_height: expected %0d, got %0d",
							want.peak_height, out_ch.peak_height);
						fault_cnt++;
					end
				end
			end
			// A fresh hold request starts a long stall counted here
			if (hold_req != hold_seen) begin
				hold_seen    <= hold_req;
				hold_left    <= LONG_HOLD;
				out_ch.ready <= 1'b0;
			end else if (hold_left > 0) begin
				hold_left    <= hold_left - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// Watchdog: abandon the run when no channel moves a beat for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			quiet_cycles = 0;
		end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
				|| (cfg_ch.valid && cfg_ch.ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	// Write one register through the config channel and mirror it in the predictor
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] value);
		@(posedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		case (idx)
			REG_THRESHOLD_START:   start_level               = value;
			REG_THRESHOLD_FLOOR:   det_cfg.threshold_floor   = value;
			REG_DECAY_FACTOR:      det_cfg.decay_factor      = value;
			REG_PEAK_FRACTION:     det_cfg.peak_fraction     = value;
			REG_CONFIRM_WAIT:      det_cfg.confirm_wait      = value[WAIT_W-1:0];
			REG_REFRACTORY_LENGTH: det_cfg.refractory_length = value[WAIT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic write_all(input int start, input int flr, input int decay,
			input int frac, input int wait_len, input int refr);
		write_reg(REG_THRESHOLD_START, CFG_DATA_W'(start));
		write_reg(REG_THRESHOLD_FLOOR, CFG_DATA_W'(flr));
		write_reg(REG_DECAY_FACTOR, CFG_DATA_W'(decay));
		write_reg(REG_PEAK_FRACTION, CFG_DATA_W'(frac));
		write_reg(REG_CONFIRM_WAIT, CFG_DATA_W'(wait_len));
		write_reg(REG_REFRACTORY_LENGTH, CFG_DATA_W'(refr));
	endtask

	// Clamp to the sample range and queue
	task automatic queue_sample(input int v);
		if (v > 32767)
			v = 32767;
		if (v < -32768)
			v = -32768;
		sample_q.push_back(v[SAMPLE_W-1:0]);
		phase_items++;
	endtask

	// One QRS-like complex: lead-in, sharp spike, sometimes a taller echo, then a quiet tail
	task automatic queue_heartbeat(input int settle);
		int amp, base, noise;
		if ($urandom_range(11) == 0) begin
			amp  = $urandom_range(1) ? 32767 : -32768;
			base = 0;
		end else begin
			amp  = $urandom_range(20000, 150);
			amp  = $urandom_range(1) ? amp : -amp;
			base = int'($urandom_range(2000)) - 1000;
		end
		noise = $urandom_range(40);
		repeat ($urandom_range(6, 1))
			queue_sample(base + int'($urandom_range(2 * noise)) - noise);
		queue_sample(base + amp / 3);
		queue_sample(base + amp);
		queue_sample(base + amp / 2);
		queue_sample(base - amp / 4);
		queue_sample(base);
		// A taller echo during the confirmation wait reopens the peak
		if ($urandom_range(4) == 0) begin
			repeat ($urandom_range(4, 1))
				queue_sample(base);
			queue_sample(base + amp);
			queue_sample(base + amp + amp / 2);
			queue_sample(base);
		end
		repeat (settle + $urandom_range(30))
			queue_sample(base + int'($urandom_range(2 * noise)) - noise);
	endtask

	// Fill one phase: mostly heartbeats sized to the current waits, some full-range noise
	task automatic fill_phase(input int n_items);
		int settle;
		settle      = int'(det_cfg.confirm_wait) + int'(det_cfg.refractory_length) + 4;
		settle      = (settle > 160) ? 160 : settle;
		phase_items = 0;
		while (phase_items < n_items) begin
			if ($urandom_range(9) == 0) begin
				repeat ($urandom_range(8, 1))
					queue_sample(int'($urandom_range(65535)) - 32768);
			end else begin
				queue_heartbeat(settle);
			end
		end
	endtask

	// Hold until every sample is taken and every prediction met, then let the core settle
	task automatic drain();
		while (sample_q.size() != 0 || in_ch.valid || predicted_results.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Full-scale steps: largest slope both ways, then a higher slope while waiting
	int directed_seq [22] = '{0, 0, 0, 0, 32767, 32767, 32767, 32767, 32767,
		32767, 32767, 32767, 32767, -32768, -32768, -32768, -32768, -32768,
		0, 0, -1, 1};

	initial begin
		in_ch.valid   = 1'b0;
		in_ch.sample  = '0;
		out_ch.ready  = 1'b0;
		cfg_ch.valid  = 1'b0;
		cfg_ch.index  = '0;
		cfg_ch.data   = '0;
		arst_n        = 1'b0;
		send_idle_pct = 19;
		recv_idle_pct = 72;

		start_level               = THRESHOLD_START_RST;
		det_cfg.threshold_floor   = THRESHOLD_FLOOR_RST;
		det_cfg.decay_factor      = DECAY_FACTOR_RST;
		det_cfg.peak_fraction     = PEAK_FRACTION_RST;
		det_cfg.confirm_wait      = CONFIRM_WAIT_RST;
		det_cfg.refractory_length = REFRACTORY_LENGTH_RST;
		det_phase   = ST_CLEAR;
		thr_q16     = {start_level, 16'd0};
		sample_cnt  = '0;
		blind_until = '0;
		cand_h      = -1;
		cand_pos    = -1;
		best_h      = -1;
		best_pos    = -1;
		confirm_at  = -1;
		foreach (sample_hist[i])
			sample_hist[i] = '0;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values, directed steps first; sender idles lightly, receiver heavily
		foreach (directed_seq[i])
			queue_sample(directed_seq[i]);
		fill_phase(200);
		drain();

		// Short waits so beats come often
		write_all(1000, 30, 65000, 39322, 8, 12);
		fill_phase(300);
		drain();

		// Low extremes: threshold collapses to zero, instant confirmation, no blind time
		send_idle_pct = 72;
		recv_idle_pct = 19;
		write_all(0, 0, 0, 65535, 0, 0);
		fill_phase(300);
		drain();

		// High extremes: threshold pinned at the top, longest waits
		write_all(65535, 65535, 65535, 0, 4095, 4095);
		fill_phase(100);
		drain();

		// No idling; hold the receiver off so the core backs up into the sample channel
		send_idle_pct = 0;
		recv_idle_pct = 0;
		write_all($urandom_range(65535), $urandom_range(200), $urandom_range(65535, 60000),
			$urandom_range(65535), $urandom_range(30, 2), $urandom_range(40));
		fill_phase(330);
		@(posedge clk);
		hold_req <= hold_req + 1;
		drain();

		write_all($urandom_range(65535), $urandom_range(120), $urandom_range(65535, 62000),
			$urandom_range(65535), $urandom_range(20, 1), $urandom_range(25));
		fill_phase(330);
		drain();

		if (predicted_results.size() != 0) begin
			$error("%0d predicted results never arrived", predicted_results.size());
			fault_cnt++;
		end
		if (fault_cnt == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

/* sim.f */
hw/rtl/qrs_pkg.sv
hw/rtl/qrs_ifs.sv
hw/rtl/qrs_cfg.sv
hw/rtl/qrs_engine.sv
hw/rtl/qrs_peak_detector_core.sv
verif/testbench.sv
